FILE: rtl/cch_pkg.sv
// shared types, widths and constants of the calibrated compass heading block
`default_nettype none

package cch_pkg;

  localparam int unsigned MAG_W     = 16;
  localparam int unsigned OFS_W     = 17;
  localparam int unsigned SCL_W     = 16;
  localparam int unsigned DIFF_W    = 19;
  localparam int unsigned PROD_W    = 36;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned VEC_W     = 53;
  localparam int unsigned ANG_W     = 26;
  localparam int unsigned HEAD_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned ROUND_SH  = 10;

  localparam logic signed [ANG_W-1:0] DEG180    = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] DEG360    = ANG_W'(360 * 65536);
  localparam logic signed [ANG_W-1:0] ROUND_ADD = ANG_W'(512);
  localparam logic [HEAD_W:0]         FULL_TURN = (HEAD_W + 1)'(23040);

  localparam logic signed [OFS_W-1:0] BIAS_X_RST  = -17'sd3805;
  localparam logic signed [OFS_W-1:0] BIAS_Y_RST  = -17'sd1743;
  localparam logic [SCL_W-1:0]        SCALE_X_RST = 16'd32768;
  localparam logic [SCL_W-1:0]        SCALE_Y_RST = 16'd31794;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_X  = 2'd0,
    REG_BIAS_Y  = 2'd1,
    REG_SCALE_X = 2'd2,
    REG_SCALE_Y = 2'd3
  } cch_reg_e;

  // calibration register set
  typedef struct packed {
    logic signed [OFS_W-1:0] bias_x;
    logic signed [OFS_W-1:0] bias_y;
    logic [SCL_W-1:0]        scale_x;
    logic [SCL_W-1:0]        scale_y;
  } cch_cal_t;

  // vector handed from cell to cell
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } cch_vec_t;

  // atan(2^-i) in 2^-16 degree units, rounded to nearest
  function automatic logic signed [ANG_W-1:0] cch_atan(input int unsigned i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:       a = ANG_W'(2949120);
      1:       a = ANG_W'(1740967);
      2:       a = ANG_W'(919879);
      3:       a = ANG_W'(466945);
      4:       a = ANG_W'(234379);
      5:       a = ANG_W'(117304);
      6:       a = ANG_W'(58666);
      7:       a = ANG_W'(29335);
      8:       a = ANG_W'(14668);
      9:       a = ANG_W'(7334);
      10:      a = ANG_W'(3667);
      11:      a = ANG_W'(1833);
      12:      a = ANG_W'(917);
      13:      a = ANG_W'(458);
      14:      a = ANG_W'(229);
      15:      a = ANG_W'(115);
      16:      a = ANG_W'(57);
      17:      a = ANG_W'(29);
      18:      a = ANG_W'(14);
      19:      a = ANG_W'(7);
      20:      a = ANG_W'(4);
      21:      a = ANG_W'(2);
      22:      a = ANG_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cch_if.sv
// valid/ready channel interfaces for samples and headings
`default_nettype none

interface cch_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface cch_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

FILE: rtl/calibrated_compass_heading.sv
// calibrated compass heading: offset/scale correction and pipelined cordic atan2
// path: calibration registers, one register per cordic cell, wrap output register
// throughput: one item per cycle unless the output stalls, no shared unit in the path
// a stalled output backs up stage by stage, empty stages still take new items
// reset clears all stage valid bits and loads the built-in calibration values
// the four calibration registers keep their value until written again
`default_nettype none

module calibrated_compass_heading #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cch_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cch_pkg::OFS_W-1:0]       cfg_data_i,
  cch_in_if.sink                               mag_in,
  cch_out_if.source                            head_out
);
  import cch_pkg::*;

  // at most ATAN_LEN stages are built, a larger CORDIC_STAGES is clipped
  localparam int unsigned NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  cch_cal_t cal_q;

  // chain links: index 0 is the pre-rotated vector, index NSTG the last cell output
  logic     link_valid [NSTG+1];
  logic     link_ready [NSTG+1];
  cch_vec_t link_vec   [NSTG+1];

  // calibration register writes, user keeps the pipeline idle; not enforced by the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.bias_x  <= BIAS_X_RST;
      cal_q.bias_y  <= BIAS_Y_RST;
      cal_q.scale_x <= SCALE_X_RST;
      cal_q.scale_y <= SCALE_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cch_reg_e'(cfg_idx_i))
        REG_BIAS_X:  cal_q.bias_x  <= $signed(cfg_data_i);
        REG_BIAS_Y:  cal_q.bias_y  <= $signed(cfg_data_i);
        REG_SCALE_X: cal_q.scale_x <= cfg_data_i[SCL_W-1:0];
        REG_SCALE_Y: cal_q.scale_y <= cfg_data_i[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: (2*raw - offset) * scale, then fold the left half-plane by 180 degrees
  cch_calib u_calib (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal_q),
    .valid_i (mag_in.valid),
    .ready_o (mag_in.ready),
    .mag_x_i (mag_in.mag_x),
    .mag_y_i (mag_in.mag_y),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .vec_o   (link_vec[0])
  );

  // row of cordic cells, cell k shifts by k and adds or removes atan(2^-k)
  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    cch_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .vec_i   (link_vec[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .vec_o   (link_vec[k+1])
    );
  end

  // back end: wrap into one turn, round, zero vector gives heading zero
  cch_wrap u_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (link_valid[NSTG]),
    .ready_o   (link_ready[NSTG]),
    .vec_i     (link_vec[NSTG]),
    .valid_o   (head_out.valid),
    .ready_i   (head_out.ready),
    .heading_o (head_out.heading)
  );

endmodule

`default_nettype wire

FILE: rtl/cch_calib.sv
// calibration multiply and half-plane pre-rotation, two pipeline registers
`default_nettype none

module cch_calib (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cch_pkg::cch_cal_t                 cal_i,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic signed [cch_pkg::MAG_W-1:0]  mag_x_i,
  input  wire logic signed [cch_pkg::MAG_W-1:0]  mag_y_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output cch_pkg::cch_vec_t                      vec_o
);
  import cch_pkg::*;

  logic                     v1_q, v2_q;
  logic                     rdy1, rdy2;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] px_d, py_d, px_q, py_q;
  logic signed [VEC_W-1:0]  xw, yw;
  cch_vec_t                 vec_d, vec_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign vec_o   = vec_q;

  // offset in half-lsb units, so the raw sample is doubled
  always_comb begin
    dx   = (DIFF_W'(mag_x_i) <<< 1) - DIFF_W'(cal_i.bias_x);
    dy   = (DIFF_W'(mag_y_i) <<< 1) - DIFF_W'(cal_i.bias_y);
    px_d = PROD_W'(dx) * PROD_W'($signed({1'b0, cal_i.scale_x}));
    py_d = PROD_W'(dy) * PROD_W'($signed({1'b0, cal_i.scale_y}));
  end

  always_comb begin
    xw         = VEC_W'(px_q) <<< FRAC_W;
    yw         = VEC_W'(py_q) <<< FRAC_W;
    vec_d.zero = (px_q == '0) && (py_q == '0);
    if (xw < 0) begin
      vec_d.x = -xw;
      vec_d.y = -yw;
      vec_d.z = DEG180;
    end else begin
      vec_d.x = xw;
      vec_d.y = yw;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (rdy2 && v1_q) vec_q <= vec_d;
  end

endmodule

`default_nettype wire

FILE: rtl/cch_cordic_cell.sv
// one vectoring cordic cell with its own pipeline register
`default_nettype none

module cch_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cch_pkg::cch_vec_t vec_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output cch_pkg::cch_vec_t      vec_o
);
  import cch_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = cch_atan(SHIFT);

  logic                    valid_q;
  logic                    rdy;
  logic signed [VEC_W-1:0] xs, ys;
  cch_vec_t                vec_d, vec_q;

  assign rdy     = !valid_q || ready_i;
  assign ready_o = rdy;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_comb begin
    xs         = vec_i.x >>> SHIFT;
    ys         = vec_i.y >>> SHIFT;
    vec_d.zero = vec_i.zero;
    // rotate toward y = 0, zero y takes the positive branch
    if (!vec_i.y[VEC_W-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ATAN;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) vec_q <= vec_d;
  end

endmodule

`default_nettype wire

FILE: rtl/cch_wrap.sv
// angle wrap into one turn, rounding to 1/64 degree, output register
`default_nettype none

module cch_wrap (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire cch_pkg::cch_vec_t          vec_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [cch_pkg::HEAD_W-1:0]      heading_o
);
  import cch_pkg::*;

  logic                    valid_q;
  logic                    rdy;
  logic signed [ANG_W-1:0] zw, zr;
  logic [HEAD_W:0]         h;
  logic [HEAD_W-1:0]       head_d, head_q;

  assign rdy       = !valid_q || ready_i;
  assign ready_o   = rdy;
  assign valid_o   = valid_q;
  assign heading_o = head_q;

  always_comb begin
    if (vec_i.z < 0) begin
      zw = vec_i.z + DEG360;
    end else if (vec_i.z >= DEG360) begin
      zw = vec_i.z - DEG360;
    end else begin
      zw = vec_i.z;
    end
    zr = zw + ROUND_ADD;
    h  = zr[ROUND_SH +: HEAD_W + 1];
    if (vec_i.zero || h >= FULL_TURN) begin
      head_d = '0;
    end else begin
      head_d = h[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) head_q <= head_d;
  end

endmodule

`default_nettype wire

FILE: rtl/cch_checker.sv
// port-level checks of the compass heading block and their bind
`default_nettype none

module cch_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [14:0] heading_i
);

  // heading never reaches a full turn
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (heading_i < 15'd23040))
    else $error("heading out of range");

  // a waiting heading holds
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(heading_i)))
    else $error("stalled heading changed");

  // with nothing at the output every stage can move, so the input is open
  a_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output empty");

  // the input side is open right after reset
  a_rst_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (in_ready_i && !out_valid_i))
    else $error("pipeline not empty after reset");

endmodule

bind calibrated_compass_heading cch_checker u_cch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (mag_in.valid),
  .in_ready_i  (mag_in.ready),
  .out_valid_i (head_out.valid),
  .out_ready_i (head_out.ready),
  .heading_i   (head_out.heading)
);

`default_nettype wire
